[src/vnls_pkg.sv]
package vnls_pkg;

	// Fixed field widths.
	localparam int POS_BITS  = 5;
	localparam int EXT_BITS  = 6;
	localparam int DIM_BITS  = 2;
	localparam int CNT_BITS  = 5;

	// Default sizes for the top-level parameters.
	localparam int SIDE_DEF       = 32;
	localparam int LABEL_BITS_DEF = 16;

	// Longest list of distinct neighbor labels: 18 face and edge neighbors in 3D.
	localparam int MAX_FOUND = 18;

	// Configuration port.
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_DIMENSIONS = 2'd0;
	localparam logic [1:0] REG_EXTENT_X   = 2'd1;
	localparam logic [1:0] REG_EXTENT_Y   = 2'd2;
	localparam logic [1:0] REG_EXTENT_Z   = 2'd3;

	// Dimension code that selects the plane window.
	localparam logic [DIM_BITS-1:0] DIM_FLAT = 2'd2;
	// Dimension code that selects the cube window; it is also the reset value.
	localparam logic [DIM_BITS-1:0] DIM_CUBE = 2'd3;

	// Function codes of an input transaction.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Control broadcast to every cell of the sorting chain.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

[src/voxel_neighbor_label_scan.sv]
// Voxel neighbor label scan.
// Input channel (in_valid / in_stall): a transaction with func write stores label at
// (pos_x, pos_y, pos_z); in the plane mode it goes to z = 0. A transaction
// with func query scans the neighbors of the position and returns the distinct labels
// that differ from the given label, ascending, one per output transaction.
// Output channel (out_valid / out_stall): each result carries neighbor_label, has_label,
// distinct_count, bad_position and last; last marks the final result of a query.
// A query with no labels gives one empty result; a position outside the extent gives
// one result with bad_position set.
// Sequence: a query walks all 27 window offsets, one store read per cycle on the single
// store port, then lets the sorting chain of 18 cells settle, then unloads one result
// per cycle while the receiver does not stall. A bad position passes through the result
// state, which loads its result into the output register.
// in_stall is high from the acceptance of a query until its last result sits in the
// output register; a new transaction may be accepted while that result still waits.
// When the receiver stalls, the output register holds its result and the unload pauses.
// Reset clears the control state and sets the registers to 3D, extents 32; the label
// store is not cleared and must be written before it is read.
// Configuration writes go over the APB port at byte addresses 0, 4, 8 and 12.
module voxel_neighbor_label_scan #(
	parameter int SIDE       = vnls_pkg::SIDE_DEF,
	parameter int LABEL_BITS = vnls_pkg::LABEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [vnls_pkg::ADDR_BITS-1:0] paddr,
	input  logic [vnls_pkg::DATA_BITS-1:0] pwdata,
	output logic [vnls_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [vnls_pkg::POS_BITS-1:0]  pos_x,
	input  logic [vnls_pkg::POS_BITS-1:0]  pos_y,
	input  logic [vnls_pkg::POS_BITS-1:0]  pos_z,
	input  logic [LABEL_BITS-1:0]          label,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [LABEL_BITS-1:0]          neighbor_label,
	output logic                           has_label,
	output logic [vnls_pkg::CNT_BITS-1:0]  distinct_count,
	output logic                           bad_position,
	output logic                           last
);

	localparam int CW    = $clog2(SIDE);
	localparam int XW    = (CW > vnls_pkg::POS_BITS) ? CW : vnls_pkg::POS_BITS;
	localparam int SW    = $clog2(SIDE + 1);
	localparam int EW    = (SW > vnls_pkg::EXT_BITS) ? SW : vnls_pkg::EXT_BITS;
	localparam int KW    = ((XW + 1) > EW) ? (XW + 1) : EW;
	localparam int AW    = 3 * CW;
	localparam int DEPTH = 2 ** AW;
	localparam int NF    = vnls_pkg::MAX_FOUND;
	localparam int STW   = $clog2(NF + 2);
	localparam logic [STW-1:0] SETTLE_LEN = STW'(NF + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_SETTLE = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t                              state_q;
	logic [vnls_pkg::DIM_BITS-1:0]       dims_q;
	logic [vnls_pkg::EXT_BITS-1:0]       ext_x_q;
	logic [vnls_pkg::EXT_BITS-1:0]       ext_y_q;
	logic [vnls_pkg::EXT_BITS-1:0]       ext_z_q;
	logic                                cfg_wr;

	logic                                flat;
	logic [EW-1:0]                       ex;
	logic [EW-1:0]                       ey;
	logic [EW-1:0]                       ez;

	logic                                in_acc;
	logic [XW-1:0]                       in_x;
	logic [XW-1:0]                       in_y;
	logic [XW-1:0]                       in_z;
	logic                                wr_in_range;
	logic                                query_bad;

	logic [XW-1:0]                       px_q;
	logic [XW-1:0]                       py_q;
	logic [XW-1:0]                       pz_q;
	logic [LABEL_BITS-1:0]               ref_q;
	logic [1:0]                          ox_q;
	logic [1:0]                          oy_q;
	logic [1:0]                          oz_q;
	logic [STW-1:0]                      settle_q;
	logic [vnls_pkg::CNT_BITS-1:0]       cnt_q;
	logic [vnls_pkg::CNT_BITS-1:0]       remain_q;
	logic                                bad_q;
	logic                                rd_vld_s1;

	logic [KW-1:0]                       nx;
	logic [KW-1:0]                       ny;
	logic [KW-1:0]                       nz;
	logic [KW-1:0]                       nx_m1;
	logic [KW-1:0]                       ny_m1;
	logic [KW-1:0]                       nz_m1;
	logic                                off_ok;
	logic                                scan_done;

	logic                                ram_we;
	logic [AW-1:0]                       ram_addr;
	logic [AW-1:0]                       wr_addr;
	logic [AW-1:0]                       rd_addr;
	logic [LABEL_BITS-1:0]               ram_rdata;

	vnls_pkg::cell_ctrl_t                cell_ctrl;
	logic                                feed_vld;
	logic [NF-1:0]                       held_vld;
	logic [LABEL_BITS-1:0]               held_val [NF];
	logic [NF-1:0]                       pass_vld;
	logic [LABEL_BITS-1:0]               pass_val [NF];
	logic [vnls_pkg::CNT_BITS-1:0]       found_cnt;

	logic                                out_free;
	logic                                out_load;
	logic                                out_valid_q;
	logic [LABEL_BITS-1:0]               out_label_q;
	logic                                out_has_q;
	logic [vnls_pkg::CNT_BITS-1:0]       out_cnt_q;
	logic                                out_bad_q;
	logic                                out_last_q;

	function automatic logic [EW-1:0] clamp_ext(input logic [vnls_pkg::EXT_BITS-1:0] e);
		logic [EW-1:0] ew;
		ew = EW'(e);
		return (ew > EW'(SIDE)) ? EW'(SIDE) : ew;
	endfunction

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= vnls_pkg::DIM_CUBE;
			ext_x_q <= 6'd32;
			ext_y_q <= 6'd32;
			ext_z_q <= 6'd32;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				vnls_pkg::REG_DIMENSIONS: dims_q  <= pwdata[vnls_pkg::DIM_BITS-1:0];
				vnls_pkg::REG_EXTENT_X:   ext_x_q <= pwdata[vnls_pkg::EXT_BITS-1:0];
				vnls_pkg::REG_EXTENT_Y:   ext_y_q <= pwdata[vnls_pkg::EXT_BITS-1:0];
				vnls_pkg::REG_EXTENT_Z:   ext_z_q <= pwdata[vnls_pkg::EXT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			vnls_pkg::REG_DIMENSIONS: prdata = vnls_pkg::DATA_BITS'(dims_q);
			vnls_pkg::REG_EXTENT_X:   prdata = vnls_pkg::DATA_BITS'(ext_x_q);
			vnls_pkg::REG_EXTENT_Y:   prdata = vnls_pkg::DATA_BITS'(ext_y_q);
			vnls_pkg::REG_EXTENT_Z:   prdata = vnls_pkg::DATA_BITS'(ext_z_q);
			default:                  prdata = '0;
		endcase
	end

	// Effective extents; the plane mode has a single layer.
	assign flat = (dims_q == vnls_pkg::DIM_FLAT);
	assign ex   = clamp_ext(ext_x_q);
	assign ey   = clamp_ext(ext_y_q);
	assign ez   = flat ? EW'(1) : clamp_ext(ext_z_q);

	// Input transaction decode.
	assign in_stall    = (state_q != S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign in_x        = XW'(pos_x);
	assign in_y        = XW'(pos_y);
	assign in_z        = flat ? '0 : XW'(pos_z);
	assign wr_in_range = (KW'(in_x) < KW'(SIDE)) && (KW'(in_y) < KW'(SIDE))
		&& (KW'(in_z) < KW'(SIDE));
	assign query_bad   = (KW'(in_x) >= KW'(ex)) || (KW'(in_y) >= KW'(ey))
		|| (KW'(in_z) >= KW'(ez));
	assign wr_addr     = {in_z[CW-1:0], in_y[CW-1:0], in_x[CW-1:0]};

	// Neighbor coordinate for the current window offset, kept one above its true value.
	assign nx     = KW'(px_q) + KW'(ox_q);
	assign ny     = KW'(py_q) + KW'(oy_q);
	assign nz     = KW'(pz_q) + KW'(oz_q);
	assign nx_m1  = nx - KW'(1);
	assign ny_m1  = ny - KW'(1);
	assign nz_m1  = nz - KW'(1);
	assign rd_addr = {nz_m1[CW-1:0], ny_m1[CW-1:0], nx_m1[CW-1:0]};

	// An offset is read when it lies inside the extent, is not the center,
	// and is not a corner in 3D; the plane mode uses only the middle layer.
	always_comb begin
		off_ok = 1'b1;
		if (ox_q == 2'd0 && px_q == '0) off_ok = 1'b0;
		if (oy_q == 2'd0 && py_q == '0) off_ok = 1'b0;
		if (oz_q == 2'd0 && pz_q == '0) off_ok = 1'b0;
		if (nx > KW'(ex) || ny > KW'(ey) || nz > KW'(ez)) off_ok = 1'b0;
		if (ox_q == 2'd1 && oy_q == 2'd1 && oz_q == 2'd1) off_ok = 1'b0;
		if (flat && oz_q != 2'd1) off_ok = 1'b0;
		if (!flat && ox_q != 2'd1 && oy_q != 2'd1 && oz_q != 2'd1) off_ok = 1'b0;
	end

	assign scan_done = (ox_q == 2'd2) && (oy_q == 2'd2) && (oz_q == 2'd2);

	// Label store.
	assign ram_we   = in_acc && (func == vnls_pkg::FUNC_WRITE) && wr_in_range;
	assign ram_addr = (state_q == S_SCAN) ? rd_addr : wr_addr;

	vnls_ram #(
		.WIDTH(LABEL_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(label),
		.rdata(ram_rdata)
	);

	// Sorting chain: read labels that differ from the reference enter at cell 0.
	assign feed_vld        = rd_vld_s1 && (ram_rdata != ref_q);
	assign out_free        = !out_valid_q || !out_stall;
	assign cell_ctrl.clear = in_acc && (func == vnls_pkg::FUNC_QUERY);
	assign cell_ctrl.shift = (state_q == S_DRAIN) && out_free;

	for (genvar i = 0; i < NF; i++) begin : g_cell
		logic                  c_in_vld;
		logic [LABEL_BITS-1:0] c_in_val;
		logic                  c_right_vld;
		logic [LABEL_BITS-1:0] c_right_val;

		if (i == 0) begin : g_head
			assign c_in_vld = feed_vld;
			assign c_in_val = ram_rdata;
		end else begin : g_body
			assign c_in_vld = pass_vld[i-1];
			assign c_in_val = pass_val[i-1];
		end

		if (i == NF - 1) begin : g_tail
			assign c_right_vld = 1'b0;
			assign c_right_val = '0;
		end else begin : g_inner
			assign c_right_vld = held_vld[i+1];
			assign c_right_val = held_val[i+1];
		end

		vnls_cell #(
			.W(LABEL_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.in_vld   (c_in_vld),
			.in_val   (c_in_val),
			.right_vld(c_right_vld),
			.right_val(c_right_val),
			.held_vld (held_vld[i]),
			.held_val (held_val[i]),
			.pass_vld (pass_vld[i]),
			.pass_val (pass_val[i])
		);
	end

	// Filled cells form a prefix, so their number is the distinct count.
	assign found_cnt = vnls_pkg::CNT_BITS'($countones(held_vld));

	// Query sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ox_q      <= 2'd0;
			oy_q      <= 2'd0;
			oz_q      <= 2'd0;
			settle_q  <= '0;
			cnt_q     <= '0;
			remain_q  <= '0;
			bad_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) && off_ok;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && func == vnls_pkg::FUNC_QUERY) begin
						ox_q <= 2'd0;
						oy_q <= 2'd0;
						oz_q <= 2'd0;
						if (query_bad) begin
							bad_q   <= 1'b1;
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (oz_q == 2'd2) begin
						oz_q <= 2'd0;
						if (oy_q == 2'd2) begin
							oy_q <= 2'd0;
							ox_q <= ox_q + 2'd1;
						end else begin
							oy_q <= oy_q + 2'd1;
						end
					end else begin
						oz_q <= oz_q + 2'd1;
					end
					if (scan_done) begin
						settle_q <= SETTLE_LEN;
						state_q  <= S_SETTLE;
					end
				end
				S_SETTLE: begin
					settle_q <= settle_q - STW'(1);
					if (settle_q == '0) begin
						cnt_q    <= found_cnt;
						remain_q <= found_cnt;
						if (found_cnt == '0) begin
							bad_q   <= 1'b0;
							state_q <= S_RESULT;
						end else begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (out_free) begin
						remain_q <= remain_q - vnls_pkg::CNT_BITS'(1);
						if (remain_q == vnls_pkg::CNT_BITS'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query operands held for the scan.
	always_ff @(posedge clk) begin
		if (in_acc && func == vnls_pkg::FUNC_QUERY) begin
			px_q  <= in_x;
			py_q  <= in_y;
			pz_q  <= in_z;
			ref_q <= label;
		end
	end

	// Output register.
	assign out_load = ((state_q == S_DRAIN) || (state_q == S_RESULT)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_DRAIN) begin
				out_label_q <= held_val[0];
				out_has_q   <= 1'b1;
				out_cnt_q   <= cnt_q;
				out_bad_q   <= 1'b0;
				out_last_q  <= (remain_q == vnls_pkg::CNT_BITS'(1));
			end else begin
				out_label_q <= '0;
				out_has_q   <= 1'b0;
				out_cnt_q   <= '0;
				out_bad_q   <= bad_q;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign neighbor_label = out_label_q;
	assign has_label      = out_has_q;
	assign distinct_count = out_cnt_q;
	assign bad_position   = out_bad_q;
	assign last           = out_last_q;

endmodule

[src/vnls_ram.sv]
module vnls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single port: a write and a registered read at one address per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[src/vnls_cell.sv]
module vnls_cell #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vnls_pkg::cell_ctrl_t ctrl,
	input  logic                 in_vld,
	input  logic [W-1:0]         in_val,
	input  logic                 right_vld,
	input  logic [W-1:0]         right_val,
	output logic                 held_vld,
	output logic [W-1:0]         held_val,
	output logic                 pass_vld,
	output logic [W-1:0]         pass_val
);

	logic         held_vld_q;
	logic [W-1:0] held_q;
	logic         pass_vld_q;
	logic [W-1:0] pass_q;

	// Valid flags: a cell fills once, a duplicate dies here, a larger value moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			held_vld_q <= right_vld;
			pass_vld_q <= 1'b0;
		end else if (in_vld) begin
			held_vld_q <= 1'b1;
			pass_vld_q <= held_vld_q && (in_val != held_q);
		end else begin
			pass_vld_q <= 1'b0;
		end
	end

	// Values: keep the smaller of held and incoming, hand the larger to the right.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			held_q <= right_val;
		end else if (in_vld) begin
			if (!held_vld_q) begin
				held_q <= in_val;
			end else if (in_val < held_q) begin
				held_q <= in_val;
				pass_q <= held_q;
			end else begin
				pass_q <= in_val;
			end
		end
	end

	assign held_vld = held_vld_q;
	assign held_val = held_q;
	assign pass_vld = pass_vld_q;
	assign pass_val = pass_q;

endmodule

[src/vnls_checker.sv]
module vnls_checker #(
	parameter int LABEL_BITS = vnls_pkg::LABEL_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          func,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [LABEL_BITS-1:0]         neighbor_label,
	input logic                          has_label,
	input logic [vnls_pkg::CNT_BITS-1:0] distinct_count,
	input logic                          bad_position,
	input logic                          last
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(neighbor_label)
			&& $stable(has_label) && $stable(distinct_count)
			&& $stable(bad_position) && $stable(last))
		else $error("result changed while stalled");

	// A position outside the extent gives a single empty, final result.
	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_position |-> last && !has_label && (distinct_count == '0))
		else $error("bad position result malformed");

	// A result without a label is always the only and final one, with count zero.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_label |-> last && (distinct_count == '0))
		else $error("empty result not final");

	// A found label claims at least one and at most MAX_FOUND neighbors, never a bad position.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_label |-> (distinct_count != '0)
			&& (distinct_count <= vnls_pkg::CNT_BITS'(vnls_pkg::MAX_FOUND))
			&& !bad_position)
		else $error("distinct count out of range");

	// An accepted query holds off the next transaction while it runs.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == vnls_pkg::FUNC_QUERY) |=> in_stall)
		else $error("query did not block the input");

endmodule

bind voxel_neighbor_label_scan vnls_checker #(
	.LABEL_BITS(LABEL_BITS)
) u_vnls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.func          (func),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.neighbor_label(neighbor_label),
	.has_label     (has_label),
	.distinct_count(distinct_count),
	.bad_position  (bad_position),
	.last          (last)
);
